/* rtl/iea_pkg.sv */
// Package with the item types, stage records and post-byte mode codes of the address unit.
`default_nettype none

package iea_pkg;

    localparam logic [3:0] MODE_POST_INC1 = 4'b0000;
    localparam logic [3:0] MODE_POST_INC2 = 4'b0001;
    localparam logic [3:0] MODE_PRE_DEC1  = 4'b0010;
    localparam logic [3:0] MODE_PRE_DEC2  = 4'b0011;
    localparam logic [3:0] MODE_NO_OFS    = 4'b0100;
    localparam logic [3:0] MODE_ACC_B     = 4'b0101;
    localparam logic [3:0] MODE_ACC_A     = 4'b0110;
    localparam logic [3:0] MODE_OFS8      = 4'b1000;
    localparam logic [3:0] MODE_OFS16     = 4'b1001;
    localparam logic [3:0] MODE_ACC_D     = 4'b1011;
    localparam logic [3:0] MODE_PCR8      = 4'b1100;
    localparam logic [3:0] MODE_PCR16     = 4'b1101;

    localparam logic [2:0] CYC_INDIRECT = 3'd3;
    localparam logic [2:0] CYC_MAX      = 3'd7;

    typedef struct packed {
        logic [7:0]  post_byte;
        logic [15:0] offset_word;
        logic [15:0] program_counter;
        logic [7:0]  acc_a;
        logic [7:0]  acc_b;
        logic [15:0] ptr_x;
        logic [15:0] ptr_y;
        logic [15:0] ptr_u;
        logic [15:0] ptr_s;
    } in_item_t;

    typedef struct packed {
        logic [15:0] address;
        logic        indirect;
        logic        pointer_write;
        logic [1:0]  pointer_select;
        logic [15:0] pointer_value;
        logic [1:0]  offset_bytes;
        logic [2:0]  extra_cycles;
        logic        illegal_mode;
    } out_item_t;

    // Flags that ride along unchanged from decode to the output stage.
    typedef struct packed {
        logic        post_inc;
        logic        indirect;
        logic        pointer_write;
        logic [1:0]  pointer_select;
        logic [1:0]  offset_bytes;
        logic [2:0]  extra_cycles;
        logic        illegal_mode;
    } ctrl_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] addend;
        ctrl_t       ctrl;
    } dec_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] sum;
        ctrl_t       ctrl;
    } sum_t;

endpackage

`default_nettype wire

/* rtl/iea_in_if.sv */
// Input channel interface carrying one post-byte with its operand context.
`default_nettype none

interface iea_in_if;
    logic               valid;
    logic               ready;
    iea_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/iea_out_if.sv */
// Output channel interface carrying one effective address result.
`default_nettype none

interface iea_out_if;
    logic               valid;
    logic               ready;
    iea_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/iea_decode.sv */
// First stage: post-byte decode, operand selection and cycle count, registered.
`default_nettype none

module iea_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire iea_pkg::in_item_t up_item,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output iea_pkg::dec_t          dn_item
);

    logic          valid_reg;
    iea_pkg::dec_t item_reg;
    iea_pkg::dec_t item_next;

    always_comb
    begin
        logic [7:0]  pb;
        logic [1:0]  sel;
        logic [15:0] r;
        logic        ind;
        logic        ill;
        logic [2:0]  cyc;
        logic [3:0]  cyc_sum;

        pb  = up_item.post_byte;
        sel = pb[6:5];
        case (sel)
            2'd0:    r = up_item.ptr_x;
            2'd1:    r = up_item.ptr_y;
            2'd2:    r = up_item.ptr_u;
            default: r = up_item.ptr_s;
        endcase
        ind     = pb[7] & pb[4];
        ill     = 1'b0;
        cyc     = 3'd0;
        cyc_sum = 4'd0;

        item_next = '0;
        item_next.base = r;

        if (!pb[7])
        begin
            item_next.addend = {{11{pb[4]}}, pb[4:0]};
            cyc = 3'd1;
        end
        else
        begin
            unique case (pb[3:0])
                iea_pkg::MODE_POST_INC1:
                begin
                    ill = ind;
                    item_next.addend = 16'h0001;
                    item_next.ctrl.post_inc = 1'b1;
                    item_next.ctrl.pointer_write = 1'b1;
                    cyc = 3'd2;
                end
                iea_pkg::MODE_POST_INC2:
                begin
                    item_next.addend = 16'h0002;
                    item_next.ctrl.post_inc = 1'b1;
                    item_next.ctrl.pointer_write = 1'b1;
                    cyc = 3'd3;
                end
                iea_pkg::MODE_PRE_DEC1:
                begin
                    ill = ind;
                    item_next.addend = 16'hFFFF;
                    item_next.ctrl.pointer_write = 1'b1;
                    cyc = 3'd2;
                end
                iea_pkg::MODE_PRE_DEC2:
                begin
                    item_next.addend = 16'hFFFE;
                    item_next.ctrl.pointer_write = 1'b1;
                    cyc = 3'd3;
                end
                iea_pkg::MODE_NO_OFS:
                begin
                    cyc = 3'd0;
                end
                iea_pkg::MODE_ACC_B:
                begin
                    item_next.addend = {{8{up_item.acc_b[7]}}, up_item.acc_b};
                    cyc = 3'd1;
                end
                iea_pkg::MODE_ACC_A:
                begin
                    item_next.addend = {{8{up_item.acc_a[7]}}, up_item.acc_a};
                    cyc = 3'd1;
                end
                iea_pkg::MODE_OFS8:
                begin
                    item_next.addend = {{8{up_item.offset_word[7]}},
                                        up_item.offset_word[7:0]};
                    item_next.ctrl.offset_bytes = 2'd1;
                    cyc = 3'd1;
                end
                iea_pkg::MODE_OFS16:
                begin
                    item_next.addend = up_item.offset_word;
                    item_next.ctrl.offset_bytes = 2'd2;
                    cyc = 3'd4;
                end
                iea_pkg::MODE_ACC_D:
                begin
                    item_next.addend = {up_item.acc_a, up_item.acc_b};
                    cyc = 3'd4;
                end
                iea_pkg::MODE_PCR8:
                begin
                    item_next.base = up_item.program_counter;
                    item_next.addend = {{8{up_item.offset_word[7]}},
                                        up_item.offset_word[7:0]};
                    item_next.ctrl.offset_bytes = 2'd1;
                    cyc = 3'd1;
                end
                iea_pkg::MODE_PCR16:
                begin
                    item_next.base = up_item.program_counter;
                    item_next.addend = up_item.offset_word;
                    item_next.ctrl.offset_bytes = 2'd2;
                    cyc = 3'd5;
                end
                default:
                begin
                    ill = 1'b1;
                end
            endcase
        end

        if (ind)
        begin
            cyc_sum = {1'b0, cyc} + {1'b0, iea_pkg::CYC_INDIRECT};
            cyc = cyc_sum[3] ? iea_pkg::CYC_MAX : cyc_sum[2:0];
        end

        item_next.ctrl.indirect = ind;
        item_next.ctrl.pointer_select = item_next.ctrl.pointer_write ? sel : 2'd0;
        item_next.ctrl.extra_cycles = cyc;

        // An illegal post-byte reports the flag alone, with every other field zero.
        if (ill)
        begin
            item_next = '0;
            item_next.ctrl.illegal_mode = 1'b1;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/iea_adder.sv */
// Second stage: the 16-bit address adder, registered.
`default_nettype none

module iea_adder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire iea_pkg::dec_t  up_item,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output iea_pkg::sum_t       dn_item
);

    logic          valid_reg;
    iea_pkg::sum_t item_reg;
    iea_pkg::sum_t item_next;

    always_comb
    begin
        item_next.base = up_item.base;
        item_next.sum  = up_item.base + up_item.addend;
        item_next.ctrl = up_item.ctrl;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/iea_result.sv */
// Third stage: address and write-back selection into the output register.
`default_nettype none

module iea_result (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire iea_pkg::sum_t  up_item,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output iea_pkg::out_item_t  dn_item
);

    logic               valid_reg;
    iea_pkg::out_item_t item_reg;
    iea_pkg::out_item_t item_next;

    always_comb
    begin
        // Post-increment uses the old pointer; pre-decrement uses the new one.
        item_next.address        = up_item.ctrl.post_inc ? up_item.base : up_item.sum;
        item_next.indirect       = up_item.ctrl.indirect;
        item_next.pointer_write  = up_item.ctrl.pointer_write;
        item_next.pointer_select = up_item.ctrl.pointer_select;
        item_next.pointer_value  = up_item.ctrl.pointer_write ? up_item.sum : 16'd0;
        item_next.offset_bytes   = up_item.ctrl.offset_bytes;
        item_next.extra_cycles   = up_item.ctrl.extra_cycles;
        item_next.illegal_mode   = up_item.ctrl.illegal_mode;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/indexed_effective_address_unit.sv */
// Top level of the indexed effective address unit: decode, add and result stages.
//
//   Channel   Direction   Carries
//   req       in          post-byte, offset word, PC, accumulators, four pointers
//   rsp       out         address, indirect, pointer write-back, bytes, cycles, illegal
//
// Each request passes the decode, add and result registers in turn.
// The pipeline takes one request in every cycle while rsp is not stalled;
// its three register stages are decode, 16-bit add and result select.
// Reset clears the stage valid bits only; nothing else needs clearing.
// A stall on rsp holds each full stage in place and back-pressures req stage by stage.
`default_nettype none

module indexed_effective_address_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iea_in_if.sink     req,
    iea_out_if.source  rsp
);

    logic          dec_valid;
    logic          dec_ready;
    iea_pkg::dec_t dec_item;
    logic          sum_valid;
    logic          sum_ready;
    iea_pkg::sum_t sum_item;

    iea_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req.valid),
        .up_ready (req.ready),
        .up_item  (req.payload),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dn_item  (dec_item)
    );

    iea_adder u_adder (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .up_item  (dec_item),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .dn_item  (sum_item)
    );

    iea_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .up_item  (sum_item),
        .dn_valid (rsp.valid),
        .dn_ready (rsp.ready),
        .dn_item  (rsp.payload)
    );

endmodule

`default_nettype wire
